// ===== rtl/phcu_pkg.sv =====
// Shared types and constants for the packet header check / unrotate block.
// Holds the item structs, request codes and status codes.
// No dependencies.
`default_nettype none

package phcu_pkg;

   // request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // status codes
   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_SHORT    = 4'd1;
   localparam logic [3:0] ST_MAGIC    = 4'd2;
   localparam logic [3:0] ST_VERSION  = 4'd3;
   localparam logic [3:0] ST_CIPHER   = 4'd4;
   localparam logic [3:0] ST_LENGTH   = 4'd5;
   localparam logic [3:0] ST_TRANSID  = 4'd6;
   localparam logic [3:0] ST_ROTATION = 4'd7;
   localparam logic [3:0] ST_OVERFLOW = 4'd8;

   localparam logic [7:0] MAGIC_HI = 8'h41;
   localparam logic [7:0] MAGIC_LO = 8'h10;

   // configuration register indexes
   localparam logic CSR_TRANS_ID = 1'b0;
   localparam logic CSR_CHECK_ID = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       last;
      logic [9:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic        is_status;
      logic [3:0]  status;
      logic [7:0]  out_byte;
      logic [10:0] packet_length;
   } rsp_item_type;

   // control from the core to the header checker
   typedef struct packed {
      logic wr_en;
      logic overflow;
      logic check_id;
   } hdr_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/packet_header_check_unrotate_core.sv =====
// Packet header check and payload unrotate, top level.
// Depends on phcu_pkg, phcu_store and phcu_hdr_check.
//
// Usage:
//   req_item is taken at a clock edge where start is high (busy is always low).
//   A load item (req_type 0) writes one packet byte into the store; the item
//   marked last produces one status item (is_status 1) carrying the check
//   result and the received byte count. A read item (req_type 1) produces one
//   data item with the byte at read_index of the packet, payload rotated back
//   right by the header's rotation byte when the last status was ok.
//   Each result appears on rsp_item for one cycle with rsp_strobe high;
//   there is no back-pressure, the receiver must take every item.
//   Requests are registered into in_ff; the result item is then registered
//   into pipe_ff alongside the store's registered read data, and rsp_strobe
//   follows pipe_valid_ff. Throughput: one item per cycle.
//   Configuration is written through csr_we/csr_index/csr_wdata while idle.
//   Reset clears the count, flags, rotation and last status; store contents
//   are not cleared and need no clearing pass.
`default_nettype none

module packet_header_check_unrotate_core #(
   parameter int STORE_DEPTH     = 1024,
   parameter int HEADER_LEN      = 17,
   parameter int TRANS_ID_OFFSET = 8,
   parameter int ROTATION_OFFSET = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire phcu_pkg::req_item_type req_item,
   output logic                        rsp_strobe,
   output phcu_pkg::rsp_item_type      rsp_item,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [63:0]            csr_wdata
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int XW = (CW > 10) ? CW + 1 : 11;

   // configuration
   logic [63:0] trans_id_ff;
   logic        check_id_ff;

   // input register
   logic                   in_valid_ff;
   phcu_pkg::req_item_type in_ff;

   // packet state
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          done_ff, done_in;
   logic [7:0]    rot_ff, rot_in;
   logic [3:0]    last_status_ff, last_status_in;

   // result stage
   logic                   pipe_valid_ff;
   logic                   pipe_zero_ff;
   phcu_pkg::rsp_item_type pipe_ff, pipe_in;
   logic                   zero_in;

   logic                   is_load, is_read;
   logic [CW-1:0]          cur_count;
   logic                   cur_ovf;
   logic                   room_left;
   phcu_pkg::hdr_ctrl_type hdr_ctrl;
   logic [3:0]             eval_status;
   logic [7:0]             eval_rot;
   logic [XW-1:0]          idx_x, cnt_x, rot_x, pos_x, src_x;
   logic [7:0]             rd_data;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_id_ff <= '0;
         check_id_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            phcu_pkg::CSR_TRANS_ID: trans_id_ff <= csr_wdata;
            phcu_pkg::CSR_CHECK_ID: check_id_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= req_item;
   end

   assign is_load = in_valid_ff && (in_ff.req_type == phcu_pkg::REQ_LOAD);
   assign is_read = in_valid_ff && (in_ff.req_type == phcu_pkg::REQ_READ);

   // a load after a finished packet starts a new one
   assign cur_count = done_ff ? '0 : count_ff;
   assign cur_ovf   = done_ff ? 1'b0 : ovf_ff;
   assign room_left = (cur_count != CW'(STORE_DEPTH));

   assign hdr_ctrl.wr_en    = is_load && room_left;
   assign hdr_ctrl.overflow = cur_ovf || !room_left;
   assign hdr_ctrl.check_id = check_id_ff;

   always_comb begin
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      done_in        = done_ff;
      rot_in         = rot_ff;
      last_status_in = last_status_ff;
      if (is_load) begin
         count_in = room_left ? cur_count + CW'(1) : cur_count;
         ovf_in   = hdr_ctrl.overflow;
         done_in  = in_ff.last;
         if (in_ff.last) begin
            rot_in         = eval_rot;
            last_status_in = eval_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         done_ff        <= 1'b0;
         rot_ff         <= '0;
         last_status_ff <= phcu_pkg::ST_OK;
      end else begin
         count_ff       <= count_in;
         ovf_ff         <= ovf_in;
         done_ff        <= done_in;
         rot_ff         <= rot_in;
         last_status_ff <= last_status_in;
      end
   end

   phcu_hdr_check #(
      .CW              (CW),
      .HEADER_LEN      (HEADER_LEN),
      .TRANS_ID_OFFSET (TRANS_ID_OFFSET),
      .ROTATION_OFFSET (ROTATION_OFFSET)
   ) u_hdr_check (
      .clock       (clock),
      .ctrl        (hdr_ctrl),
      .wr_pos      (cur_count),
      .wr_data     (in_ff.data_byte),
      .new_count   (count_in),
      .expected_id (trans_id_ff),
      .status      (eval_status),
      .rotation    (eval_rot)
   );

   // unrotated read address
   assign idx_x = XW'(in_ff.read_index);
   assign cnt_x = XW'(count_ff);
   assign rot_x = XW'(rot_ff);
   assign pos_x = idx_x - XW'(HEADER_LEN);

   always_comb begin
      src_x = idx_x;
      if (done_ff && last_status_ff == phcu_pkg::ST_OK && idx_x >= XW'(HEADER_LEN)) begin
         if (pos_x < rot_x) begin
            src_x = cnt_x - rot_x + pos_x;
         end else begin
            src_x = XW'(HEADER_LEN) + pos_x - rot_x;
         end
      end
   end

   phcu_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (hdr_ctrl.wr_en),
      .wr_addr (cur_count[AW-1:0]),
      .wr_data (in_ff.data_byte),
      .rd_en   (is_read),
      .rd_addr (src_x[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      pipe_in.is_status     = is_load;
      pipe_in.out_byte      = '0;
      if (is_load) begin
         pipe_in.status        = eval_status;
         pipe_in.packet_length = 11'(count_in);
         zero_in               = 1'b1;
      end else begin
         pipe_in.status        = last_status_ff;
         pipe_in.packet_length = 11'(count_ff);
         zero_in               = (idx_x >= cnt_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= is_read || (is_load && in_ff.last);
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff      <= pipe_in;
      pipe_zero_ff <= zero_in;
   end

   always_comb begin
      rsp_item          = pipe_ff;
      rsp_item.out_byte = pipe_zero_ff ? 8'h00 : rd_data;
   end

   assign rsp_strobe = pipe_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/phcu_store.sv =====
// Packet byte store: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module phcu_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/phcu_hdr_check.sv =====
// Header shadow registers and the end-of-packet status evaluation.
// The byte being loaded this cycle is folded into the header view.
// Depends on phcu_pkg.
`default_nettype none

module phcu_hdr_check #(
   parameter int CW              = 11,
   parameter int HEADER_LEN      = 17,
   parameter int TRANS_ID_OFFSET = 8,
   parameter int ROTATION_OFFSET = 16
) (
   input  wire logic                  clock,
   input  wire phcu_pkg::hdr_ctrl_type ctrl,
   input  wire logic [CW-1:0]         wr_pos,
   input  wire logic [7:0]            wr_data,
   input  wire logic [CW-1:0]         new_count,
   input  wire logic [63:0]           expected_id,
   output logic      [3:0]            status,
   output logic      [7:0]            rotation
);

   localparam int HCAP0 = (HEADER_LEN > ROTATION_OFFSET + 1) ? HEADER_LEN : ROTATION_OFFSET + 1;
   localparam int HCAP  = (HCAP0 > TRANS_ID_OFFSET + 8) ? HCAP0 : TRANS_ID_OFFSET + 8;
   localparam int LW    = (CW > 16) ? CW : 16;
   localparam int RW    = (CW > 8) ? CW : 8;

   logic [7:0] shadow_ff [HCAP];
   logic [7:0] hv [HCAP];
   logic       id_bad;
   logic [LW-1:0] len_field;
   logic [RW-1:0] room;

   always_ff @(posedge clock) begin
      for (int i = 0; i < HCAP; i++) begin
         if (ctrl.wr_en && wr_pos == CW'(i)) begin
            shadow_ff[i] <= wr_data;
         end
      end
   end

   // header view: bytes at or past the count read as zero
   always_comb begin
      for (int i = 0; i < HCAP; i++) begin
         if (CW'(i) >= new_count) begin
            hv[i] = 8'h00;
         end else if (ctrl.wr_en && wr_pos == CW'(i)) begin
            hv[i] = wr_data;
         end else begin
            hv[i] = shadow_ff[i];
         end
      end
   end

   always_comb begin
      id_bad = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (hv[TRANS_ID_OFFSET + k] != expected_id[63 - 8*k -: 8]) begin
            id_bad = 1'b1;
         end
      end
   end

   assign len_field = LW'({hv[4], hv[5]});
   assign room      = RW'(new_count - CW'(HEADER_LEN));
   assign rotation  = hv[ROTATION_OFFSET];

   always_comb begin
      priority if (ctrl.overflow) begin
         status = phcu_pkg::ST_OVERFLOW;
      end else if (new_count < CW'(HEADER_LEN)) begin
         status = phcu_pkg::ST_SHORT;
      end else if (hv[0] != phcu_pkg::MAGIC_HI || hv[1] != phcu_pkg::MAGIC_LO) begin
         status = phcu_pkg::ST_MAGIC;
      end else if ({hv[2], hv[3]} != 16'd1) begin
         status = phcu_pkg::ST_VERSION;
      end else if ({hv[6], hv[7]} != 16'd0) begin
         status = phcu_pkg::ST_CIPHER;
      end else if (len_field != LW'(new_count)) begin
         status = phcu_pkg::ST_LENGTH;
      end else if (ctrl.check_id && id_bad) begin
         status = phcu_pkg::ST_TRANSID;
      end else if (RW'(rotation) > room) begin
         status = phcu_pkg::ST_ROTATION;
      end else begin
         status = phcu_pkg::ST_OK;
      end
   end

endmodule

`default_nettype wire
